// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked and disabled during reset.
// Defining ASSERT_OFF turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// pre holds -> post holds in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// pre holds -> post holds in the cycle after
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

// cond never holds
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/itoa_fmt_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_fmt_pkg
// Shared types, character codes and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

	// decimal padding limit; the pad compare runs at PAD_W bits, wide enough
	// for any limit up to 63 and for the 5-bit pad field
	localparam int unsigned MAX_PAD = 20;
	localparam int unsigned PAD_W   = 6;

	localparam int unsigned DEC_DIGITS = 10;   // digits of a 32-bit value
	localparam int unsigned HEX_DIGITS = 8;

	// floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for any 32-bit x
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;

	typedef enum logic [1:0] {
		MODE_UDEC = 2'd0,
		MODE_SDEC = 2'd1,
		MODE_HEX  = 2'd2,
		MODE_BIN  = 2'd3
	} mode_t;

	localparam logic [6:0] CH_ZERO    = 7'h30;
	localparam logic [6:0] CH_ONE     = 7'h31;
	localparam logic [6:0] CH_MINUS   = 7'h2D;
	localparam logic [6:0] CH_X       = 7'h78;
	localparam logic [6:0] CH_SPACE   = 7'h20;
	localparam logic [6:0] HEX_LETTER = 7'd55;   // 'A' - 10

	function automatic logic [6:0] hex_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO | {3'b000, d};
		end else begin
			c = {3'b000, d} + HEX_LETTER;
		end
		return c;
	endfunction

endpackage

// ===== rtl/itoa_fmt_if.sv =====
// ----------------------------------------------------------------------------
// itoa_fmt_if
// Valid/ready channels of the formatter: number words in, character words out.
// ----------------------------------------------------------------------------
interface itoa_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] value;
	logic [4:0]  pad_width;
	logic [2:0]  byte_count;

	modport source (output valid, mode, value, pad_width, byte_count, input ready);
	modport sink   (input valid, mode, value, pad_width, byte_count, output ready);
endinterface

interface itoa_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] text_char;
	logic       last;

	modport source (output valid, text_char, last, input ready);
	modport sink   (input valid, text_char, last, output ready);
endinterface

// ===== rtl/itoa_fmt_div10.sv =====
// ----------------------------------------------------------------------------
// itoa_fmt_div10
// Divide-by-ten unit: reciprocal multiply registered, then quotient and
// remainder in the cycle after. x must hold steady across both cycles.
// ----------------------------------------------------------------------------
module itoa_fmt_div10
	import itoa_fmt_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] x,
	output logic [28:0] q,
	output logic [3:0]  r
);

	logic [63:0] prod_s1;
	logic [31:0] q10;
	logic [31:0] rem;

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(x) * 64'(RECIP10);
	end

	assign q   = prod_s1[RECIP_SHIFT +: 29];
	// q * 10 as two shifts, exact since q * 10 <= x
	assign q10 = {q, 3'b000} + {2'b00, q, 1'b0};
	assign rem = x - q10;
	assign r   = rem[3:0];

endmodule

// ===== rtl/integer_to_ascii_formatter_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one 32-bit number as unsigned/signed decimal, hex or binary text,
// one ASCII character word at a time, last set on the final character.
// ----------------------------------------------------------------------------
// Timing: one number is taken, then the block is busy until its last
// character has been handed to the output register. Decimal works out
// its digits (up to 10) in the shared divide-by-ten unit, each in a
// product phase and then a store phase; hex strips leading zero nibbles
// in turn, keeping at least one, then moves on; binary starts at once.
// After that one character leaves per cycle while the sink is ready, at
// most 39 characters. The next number is taken while the last character
// waits.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
	import itoa_fmt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	itoa_in_if.sink    item,
	itoa_out_if.source chars
);

	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_DIV   = 4'b0010,
		S_HNORM = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t      state_q;
	mode_t       mode_q;
	logic [31:0] sh_q;
	logic [4:0]  cnt_q;
	logic [PAD_W-1:0] zeros_q;
	logic        neg_q;
	logic [1:0]  pre_q;
	logic [1:0]  bytes_q;
	logic        spc_q;
	logic        ph_q;
	logic [3:0]  digit_q [DEC_DIGITS];
	logic [6:0]  text_q;
	logic        last_q;
	logic        ovalid_q;

	logic [28:0] quo;
	logic [3:0]  rem;

	itoa_fmt_div10 u_div10 (
		.clk (clk),
		.x   (sh_q),
		.q   (quo),
		.r   (rem)
	);

	// ---- input decode ----
	logic [PAD_W-1:0] pad_sat;
	logic [1:0]       bsel;
	logic [31:0]      bin_init;

	always_comb begin
		if (PAD_W'(item.pad_width) > PAD_W'(MAX_PAD)) begin
			pad_sat = PAD_W'(MAX_PAD);
		end else begin
			pad_sat = PAD_W'(item.pad_width);
		end
		if (item.byte_count == 3'd0) begin
			bsel = 2'd0;
		end else if (item.byte_count > 3'd4) begin
			bsel = 2'd3;
		end else begin
			bsel = 2'(item.byte_count - 3'd1);
		end
		// left-justify the shown bytes
		case (bsel)
			2'd0:    bin_init = {item.value[7:0], 24'b0};
			2'd1:    bin_init = {item.value[15:0], 16'b0};
			2'd2:    bin_init = {item.value[23:0], 8'b0};
			default: bin_init = item.value;
		endcase
	end

	// ---- digit count at the end of division ----
	logic [PAD_W-1:0] ndig;
	assign ndig = PAD_W'(cnt_q) + PAD_W'(1);

	// ---- character generation ----
	logic             advance;
	logic [6:0]       ch_d;
	logic             last_d;
	logic [31:0]      sh_nx;
	logic [4:0]       cnt_nx;
	logic [PAD_W-1:0] zeros_nx;
	logic             neg_nx;
	logic [1:0]       pre_nx;
	logic             spc_nx;
	logic [3:0]       dig_idx;

	assign advance = (state_q == S_EMIT) && (!ovalid_q || chars.ready);
	assign dig_idx = 4'(cnt_q - 5'd1);

	always_comb begin
		ch_d     = CH_ZERO;
		last_d   = 1'b0;
		sh_nx    = sh_q;
		cnt_nx   = cnt_q;
		zeros_nx = zeros_q;
		neg_nx   = neg_q;
		pre_nx   = pre_q;
		spc_nx   = spc_q;
		case (mode_q)
			MODE_UDEC, MODE_SDEC: begin
				if (neg_q) begin
					ch_d   = CH_MINUS;
					neg_nx = 1'b0;
				end else if (zeros_q != '0) begin
					ch_d     = CH_ZERO;
					zeros_nx = zeros_q - PAD_W'(1);
				end else begin
					ch_d   = CH_ZERO | {3'b000, digit_q[dig_idx]};
					cnt_nx = cnt_q - 5'd1;
					last_d = (cnt_q == 5'd1);
				end
			end
			MODE_HEX: begin
				if (pre_q == 2'd2) begin
					ch_d   = CH_ZERO;
					pre_nx = 2'd1;
				end else if (pre_q == 2'd1) begin
					ch_d   = CH_X;
					pre_nx = 2'd0;
				end else begin
					ch_d   = hex_char(sh_q[31:28]);
					sh_nx  = {sh_q[27:0], 4'b0};
					cnt_nx = cnt_q - 5'd1;
					last_d = (cnt_q == 5'd1);
				end
			end
			default: begin
				// space ahead of every nibble group but the first
				if (cnt_q != 5'd0 && cnt_q[1:0] == 2'b00 && !spc_q) begin
					ch_d   = CH_SPACE;
					spc_nx = 1'b1;
				end else begin
					ch_d   = sh_q[31] ? CH_ONE : CH_ZERO;
					sh_nx  = {sh_q[30:0], 1'b0};
					cnt_nx = cnt_q + 5'd1;
					spc_nx = 1'b0;
					last_d = (cnt_q == {bytes_q, 3'b111});
				end
			end
		endcase
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= MODE_UDEC;
			sh_q     <= '0;
			cnt_q    <= '0;
			zeros_q  <= '0;
			neg_q    <= 1'b0;
			pre_q    <= '0;
			bytes_q  <= '0;
			spc_q    <= 1'b0;
			ph_q     <= 1'b0;
			text_q   <= '0;
			last_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			// a new word replaces the one taken at this edge
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (chars.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						mode_q  <= mode_t'(item.mode);
						neg_q   <= 1'b0;
						spc_q   <= 1'b0;
						ph_q    <= 1'b0;
						zeros_q <= pad_sat;
						bytes_q <= bsel;
						pre_q   <= 2'd2;
						case (mode_t'(item.mode))
							MODE_UDEC: begin
								sh_q    <= item.value;
								cnt_q   <= '0;
								state_q <= S_DIV;
							end
							MODE_SDEC: begin
								neg_q   <= item.value[31];
								sh_q    <= item.value[31] ? (~item.value + 32'd1) : item.value;
								cnt_q   <= '0;
								state_q <= S_DIV;
							end
							MODE_HEX: begin
								sh_q    <= item.value;
								cnt_q   <= 5'(HEX_DIGITS);
								state_q <= S_HNORM;
							end
							default: begin
								sh_q    <= bin_init;
								cnt_q   <= '0;
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_DIV: begin
					// first phase lets the unit register the product
					ph_q <= ~ph_q;
					if (ph_q) begin
						sh_q  <= {3'b000, quo};
						cnt_q <= cnt_q + 5'd1;
						if (quo == '0) begin
							zeros_q <= (zeros_q > ndig) ? (zeros_q - ndig) : '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_HNORM: begin
					if (sh_q[31:28] == 4'h0 && cnt_q > 5'd1) begin
						sh_q  <= {sh_q[27:0], 4'b0};
						cnt_q <= cnt_q - 5'd1;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (advance) begin
						text_q   <= ch_d;
						last_q   <= last_d;
						sh_q     <= sh_nx;
						cnt_q    <= cnt_nx;
						zeros_q  <= zeros_nx;
						neg_q    <= neg_nx;
						pre_q    <= pre_nx;
						spc_q    <= spc_nx;
						if (last_d) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// digit store, least significant digit first
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && ph_q) begin
			digit_q[cnt_q[3:0]] <= rem;
		end
	end

	assign item.ready      = (state_q == S_IDLE);
	assign chars.valid     = ovalid_q;
	assign chars.text_char = text_q;
	assign chars.last      = last_q;

	// ---- checks ----
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, item.valid && item.ready, state_q != S_IDLE, "number taken but sequencer still idle")
	`ASSERT_NEXT(a_idle_after_last, clk, arst_n, advance && last_d, state_q == S_IDLE && last_q, "last character did not end the number")
	`ASSERT_NEVER(a_digit_count, clk, arst_n, state_q == S_DIV && cnt_q > 5'd9, "more than ten decimal digits")
	`ASSERT_NEVER(a_hex_count, clk, arst_n, state_q == S_HNORM && cnt_q == 5'd0, "hex nibble count ran out")

endmodule
